FILE: design/assert_macros.svh
// Assertion macros used by the tokenizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: design/cct_pkg.sv
// Types, codes and the character classifier shared by the tokenizer modules.
`timescale 1ns / 1ps

package cct_pkg;

  // Lexer states, also the token classes reported with each token.
  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_SPACE  = 3'd1;
  localparam logic [2:0] ST_WORD   = 3'd2;
  localparam logic [2:0] ST_NUMBER = 3'd3;
  localparam logic [2:0] ST_SYMBOL = 3'd4;
  // In the from field of an override this means every state; in the to field,
  // this value and anything above it means error.
  localparam logic [2:0] ST_ALL    = 3'd5;
  localparam logic [2:0] ST_ERROR  = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDE_SUBST = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRIDE_A = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRIDE_B = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRIDE_C = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRIDE_D = 3'd4;
  localparam int unsigned CFG_OVERRIDE_REGS = 4;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [7:0] WIDE_SUBST_RESET = 8'd63;
  localparam logic [15:0] TOKEN_LENGTH_MAX = 16'hFFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] symbol;
  } char_t;

  typedef struct packed {
    logic [2:0]  token_state;
    logic [15:0] token_length;
    logic        is_error;
  } token_t;

  // Layout of one transition override register.
  typedef struct packed {
    logic       valid;
    logic [2:0] from_state;
    logic [7:0] symbol;
    logic [2:0] to_state;
    logic       accept;
  } ovr_t;

  // C locale classification of a byte into the state it leads to.
  function automatic logic [2:0] class_of(input logic [7:0] b);
    logic [2:0] cls;
    if (b == 8'd0) begin
      cls = ST_START;
    end else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) begin
      cls = ST_WORD;
    end else if (b >= 8'd48 && b <= 8'd57) begin
      cls = ST_NUMBER;
    end else if ((b >= 8'd9 && b <= 8'd13) || b == 8'd32) begin
      cls = ST_SPACE;
    end else begin
      cls = ST_SYMBOL;
    end
    return cls;
  endfunction

endpackage

FILE: design/char_class_tokenizer.sv
// Top level of the character-class tokenizer: input stage, lexer state and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Signals                              Direction  Transaction
// char      char_valid, char_ready, char_data    in         one character or restart
// token     token_valid, token_ready, token_data out        one finished token or error
// cfg       cfg_valid, cfg_ready, cfg_index,     in         one register write
//           cfg_data
//
// The block takes one character per cycle. An accepted character waits in the input
// register until the token register can take a value, and its token, if any, is loaded
// at that edge. A waiting token holds the input register, so char_ready is low while
// both are full. Synchronous reset clears the lexer state, the run length, all valid
// flags and the configuration registers; configuration writes are always taken at once.
module char_class_tokenizer #(
  parameter int LENGTH_BITS    = 16,
  parameter int OVERRIDE_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                char_valid,
  output logic                                char_ready,
  input  cct_pkg::char_t                      char_data,
  output logic                                token_valid,
  input  logic                                token_ready,
  output cct_pkg::token_t                     token_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cct_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import cct_pkg::*;

  // Only four override registers exist, so at most four slots are ever live.
  localparam int SLOTS = (OVERRIDE_SLOTS < CFG_OVERRIDE_REGS) ?
                         OVERRIDE_SLOTS : CFG_OVERRIDE_REGS;

  logic                   in_valid_q;
  char_t                  in_q;
  logic [2:0]             lexer_state;
  logic [LENGTH_BITS-1:0] run_length;
  logic [7:0]             substitute;
  ovr_t [SLOTS-1:0]       ovr;

  logic                   advance;
  logic                   process;
  logic                   emit;
  token_t                 result;
  logic [2:0]             lexer_state_next;
  logic [LENGTH_BITS-1:0] run_length_next;

  // The token register can take a new value when it is empty or being drained.
  assign advance    = !token_valid || token_ready;
  assign process    = in_valid_q && advance;
  assign char_ready = !in_valid_q || advance;
  assign cfg_ready  = 1'b1;

  cct_cfg_regs #(
    .SLOTS(SLOTS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .substitute(substitute),
    .ovr       (ovr)
  );

  cct_step #(
    .LENGTH_BITS(LENGTH_BITS),
    .SLOTS      (SLOTS)
  ) u_step (
    .item           (in_q),
    .cur_state      (lexer_state),
    .run_length     (run_length),
    .substitute     (substitute),
    .ovr            (ovr),
    .emit           (emit),
    .result         (result),
    .next_state     (lexer_state_next),
    .next_run_length(run_length_next)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      token_valid <= 1'b0;
      lexer_state <= ST_START;
      run_length  <= '0;
    end else begin
      if (char_ready) begin
        in_valid_q <= char_valid;
      end
      if (advance) begin
        token_valid <= process && emit;
      end
      if (process) begin
        lexer_state <= lexer_state_next;
        run_length  <= run_length_next;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_q <= char_data;
    end
    if (process && emit) begin
      token_data <= result;
    end
  end

  `ASSERT_NEVER(a_state_range, clk, rst, lexer_state > ST_SYMBOL,
    "lexer state left the range of token classes")

  `ASSERT_CLK(a_error_zero_fields, clk, rst,
    (token_valid && token_data.is_error) |->
      (token_data.token_state == ST_START && token_data.token_length == 16'd0),
    "error token carries a nonzero class or length")

  `ASSERT_CLK(a_input_hold, clk, rst,
    (in_valid_q && token_valid && !token_ready) |=> (in_valid_q && $stable(in_q)),
    "input register changed while the token register was stalled")

  `ASSERT_CLK(a_restart_clears, clk, rst,
    (process && in_q.kind) |=> (lexer_state == ST_START && run_length == '0),
    "restart did not return the lexer to start with zero length")

endmodule

FILE: design/cct_cfg_regs.sv
// Configuration registers: the wide-character substitute and the override slots.
`timescale 1ns / 1ps

module cct_cfg_regs #(
  parameter int SLOTS = 4
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_valid,
  input  logic [cct_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  logic [cct_pkg::CFG_DATA_BITS-1:0]           cfg_data,
  output logic [7:0]                                  substitute,
  output cct_pkg::ovr_t [SLOTS-1:0]                   ovr
);
  import cct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      substitute <= WIDE_SUBST_RESET;
      ovr        <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDE_SUBST) begin
        substitute <= cfg_data[7:0];
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (cfg_index == CFG_OVERRIDE_A + CFG_INDEX_BITS'(i)) begin
          ovr[i] <= ovr_t'(cfg_data);
        end
      end
    end
  end

endmodule

FILE: design/cct_step.sv
// Next-state logic: classification, core transition, overrides and the token result.
`timescale 1ns / 1ps

module cct_step #(
  parameter int LENGTH_BITS = 16,
  parameter int SLOTS       = 4
) (
  input  cct_pkg::char_t                item,
  input  logic [2:0]                    cur_state,
  input  logic [LENGTH_BITS-1:0]        run_length,
  input  logic [7:0]                    substitute,
  input  cct_pkg::ovr_t [SLOTS-1:0]     ovr,
  output logic                          emit,
  output cct_pkg::token_t               result,
  output logic [2:0]                    next_state,
  output logic [LENGTH_BITS-1:0]        next_run_length
);
  import cct_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [7:0]             b;
  logic [2:0]             cls;
  logic [2:0]             to_state;
  logic                   accept;
  logic                   err;
  logic [LENGTH_BITS-1:0] base_len;
  logic [32:0]            run_wide;

  assign b        = (|item.symbol[15:8]) ? substitute : item.symbol[7:0];
  assign cls      = class_of(b);
  assign run_wide = 33'(run_length);

  always_comb begin
    to_state = cls;
    accept   = (cur_state == ST_SYMBOL) || (cur_state != ST_START && cls != cur_state);
    err      = 1'b0;
    // Later slots have higher priority, so the last match wins.
    for (int i = 0; i < SLOTS; i++) begin
      if (ovr[i].valid && ovr[i].symbol == b &&
          (ovr[i].from_state == cur_state || ovr[i].from_state == ST_ALL)) begin
        to_state = ovr[i].to_state;
        accept   = ovr[i].accept;
        err      = ovr[i].to_state >= ST_ERROR;
      end
    end
    if (cur_state == ST_START) begin
      accept = 1'b0;
    end
  end

  always_comb begin
    emit            = 1'b0;
    result          = '0;
    next_state      = cur_state;
    next_run_length = run_length;
    base_len        = run_length;
    if (item.kind) begin
      next_state      = ST_START;
      next_run_length = '0;
    end else if (err) begin
      // A refused symbol reports an error and leaves the state alone.
      emit            = 1'b1;
      result.is_error = 1'b1;
    end else begin
      if (accept) begin
        emit                = 1'b1;
        result.token_state  = cur_state;
        result.token_length = (run_wide > 33'(TOKEN_LENGTH_MAX)) ?
                              TOKEN_LENGTH_MAX : run_wide[15:0];
        base_len            = '0;
      end
      next_run_length = base_len;
      if (to_state != ST_START && base_len != LEN_MAX) begin
        next_run_length = base_len + LENGTH_BITS'(1);
      end
      next_state = to_state;
    end
  end

endmodule

FILE: verif/token_checker.sv
// Checker for the tokenizer: tracks its configuration, predicts each token and compares.
`timescale 1ns / 1ps

module token_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                char_valid,
  input  logic                                char_ready,
  input  cct_pkg::char_t                      char_data,
  input  logic                                token_valid,
  input  logic                                token_ready,
  input  cct_pkg::token_t                     token_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [cct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cct_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int unsigned                         mismatches,
  output int unsigned                         tokens_owed
);
  import cct_pkg::*;

  // Shadow of the lexer and of its registers.
  logic [2:0]  lex_state;
  logic [15:0] run_count;
  logic [7:0]  subst_byte;
  ovr_t        overrides [CFG_OVERRIDE_REGS];

  token_t      expected_tokens [$];

  function automatic logic [2:0] byte_class(input logic [7:0] b);
    if (b == 8'd0) return ST_START;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return ST_WORD;
    if (b >= "0" && b <= "9") return ST_NUMBER;
    if ((b >= 8'd9 && b <= 8'd13) || b == " ") return ST_SPACE;
    return ST_SYMBOL;
  endfunction

  // Advances the shadow lexer by one character; emit is set when a token results.
  task automatic lex_char(input char_t c, output bit emit, output token_t tok);
    logic [7:0] b;
    logic [2:0] cls;
    logic [2:0] next_state;
    bit         accept;
    bit         refused;
    emit = 1'b0;
    tok = '0;
    if (c.kind) begin
      lex_state = ST_START;
      run_count = '0;
      return;
    end
    b = (c.symbol[15:8] != 8'd0) ? subst_byte : c.symbol[7:0];
    cls = byte_class(b);
    next_state = cls;
    accept = (lex_state == ST_SYMBOL) || (lex_state != ST_START && cls != lex_state);
    refused = 1'b0;
    // Later slots take priority, so the last match wins.
    for (int i = 0; i < CFG_OVERRIDE_REGS; i++) begin
      if (overrides[i].valid && overrides[i].symbol == b &&
          (overrides[i].from_state == lex_state || overrides[i].from_state == ST_ALL)) begin
        next_state = overrides[i].to_state;
        accept = overrides[i].accept;
        refused = (overrides[i].to_state >= ST_ERROR);
      end
    end
    if (lex_state == ST_START) accept = 1'b0;
    if (refused) begin
      emit = 1'b1;
      tok.is_error = 1'b1;
      return;
    end
    if (accept) begin
      emit = 1'b1;
      tok.token_state = lex_state;
      tok.token_length = run_count;
      run_count = '0;
    end
    if (next_state != ST_START && run_count != TOKEN_LENGTH_MAX) run_count++;
    lex_state = next_state;
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("time %0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    bit     emit;
    token_t tok;
    token_t want;
    if (rst) begin
      lex_state = ST_START;
      run_count = '0;
      subst_byte = WIDE_SUBST_RESET;
      for (int i = 0; i < CFG_OVERRIDE_REGS; i++) overrides[i] = '0;
      expected_tokens.delete();
      mismatches = 0;
      tokens_owed = 0;
    end else begin
      // Retire the oldest expectation before queueing a new one.
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("time %0t: token with none expected: state %0d length %0d error %0b",
                   $time, token_data.token_state, token_data.token_length,
                   token_data.is_error);
        end else begin
          want = expected_tokens.pop_front();
          report_field("token_state", want.token_state, token_data.token_state);
          report_field("token_length", want.token_length, token_data.token_length);
          report_field("is_error", want.is_error, token_data.is_error);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDE_SUBST) begin
          subst_byte = cfg_data[7:0];
        end else if (cfg_index <= CFG_OVERRIDE_D) begin
          overrides[2'(cfg_index - CFG_OVERRIDE_A)] = cfg_data;
        end
      end
      if (char_valid && char_ready) begin
        lex_char(char_data, emit, tok);
        if (emit) expected_tokens.push_back(tok);
      end
      tokens_owed = expected_tokens.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the tokenizer testbench: clock, reset, stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import cct_pkg::*;

  // Input kinds of a char transaction.
  localparam logic KIND_SYMBOL  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Character classes used when building text.
  localparam int CLS_LETTER = 0;
  localparam int CLS_DIGIT  = 1;
  localparam int CLS_SPACE  = 2;
  localparam int CLS_OTHER  = 3;

  // A from state above ST_ALL can never match.
  localparam logic [2:0] FROM_NOWHERE = ST_ALL + 3'd1;
  localparam logic [2:0] TO_TOP       = 3'd7;

  // Cycles with no transaction on any channel before the run is declared hung. The longest
  // legitimate quiet stretch is the receiver hold-off below plus a few random gaps.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  // A result passes through the input and token registers after its character; wait a little longer.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Letters in the long word of the directed text.
  localparam int unsigned LONG_WORD = 50;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       char_valid;
  logic                       char_ready;
  char_t                      char_data;
  logic                       token_valid;
  logic                       token_ready = 1'b0;
  token_t                     token_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0]   cfg_data;

  int unsigned mismatches;
  int unsigned tokens_owed;

  // Idling controls, in percent of cycles. A hold-off is requested by bumping
  // hold_requests; the receiver notices the change and counts the hold-off itself.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  // Override register values planned for the next configuration, and the bytes that
  // those overrides match, so that text can be steered onto them.
  ovr_t       plan [CFG_OVERRIDE_REGS];
  logic [7:0] hot_bytes [CFG_OVERRIDE_REGS];

  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  char_class_tokenizer u_top (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_data   (char_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  token_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_data   (char_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .tokens_owed (tokens_owed)
  );

  // The token receiver. A requested hold-off is counted down here at each falling edge, and
  // during it the receiver takes nothing; otherwise it stalls at random.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      token_ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      token_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      token_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog: a long stretch with no transaction on any channel means the block hung.
  always @(posedge clk) begin
    if ((char_valid && char_ready) || (token_valid && token_ready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("[char_class_tokenizer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic char_t make_char(input logic kind, input logic [15:0] code);
    char_t c;
    c.kind = kind;
    c.symbol = code;
    return c;
  endfunction

  function automatic ovr_t make_override(input logic [2:0] from_state, input logic [7:0] b,
                                         input logic [2:0] to_state, input logic accept);
    ovr_t r;
    r.valid = 1'b1;
    r.from_state = from_state;
    r.symbol = b;
    r.to_state = to_state;
    r.accept = accept;
    return r;
  endfunction

  // A random byte of the given class.
  function automatic logic [7:0] class_byte(input int cls);
    logic [7:0] b;
    int unsigned pick;
    case (cls)
      CLS_LETTER: begin
        b = $urandom_range(1) ? 8'($urandom_range("Z", "A")) : 8'($urandom_range("z", "a"));
      end
      CLS_DIGIT: begin
        b = 8'($urandom_range("9", "0"));
      end
      CLS_SPACE: begin
        pick = $urandom_range(5);
        b = (pick == 5) ? " " : 8'(9 + pick);
      end
      default: begin
        // Every gap between the other classes, control bytes and the top half included.
        case ($urandom_range(5))
          0: b = 8'($urandom_range(8, 1));
          1: b = 8'($urandom_range(31, 14));
          2: b = 8'($urandom_range(47, 33));
          3: b = 8'($urandom_range(64, 58));
          4: b = 8'($urandom_range(96, 91));
          default: b = 8'($urandom_range(255, 123));
        endcase
      end
    endcase
    return b;
  endfunction

  // One character of a run of the given class, with occasional noise: restarts, wide
  // codes, end markers and the bytes that the current overrides match.
  function automatic char_t text_char(input int cls);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return make_char(KIND_RESTART, 16'($urandom_range(16'hFFFF)));
    if (roll < 7) return make_char(KIND_SYMBOL, 16'($urandom_range(16'hFFFF, 16'h0100)));
    if (roll < 11) return make_char(KIND_SYMBOL, 16'd0);
    if (roll < 21) begin
      return make_char(KIND_SYMBOL,
                       {8'd0, hot_bytes[2'($urandom_range(CFG_OVERRIDE_REGS - 1))]});
    end
    return make_char(KIND_SYMBOL, {8'd0, class_byte(cls)});
  endfunction

  function automatic ovr_t random_override();
    ovr_t r;
    r.valid = ($urandom_range(7) != 0);
    r.from_state = 3'($urandom_range(7));
    r.symbol = ($urandom_range(4) == 0) ? 8'd0 : class_byte($urandom_range(CLS_OTHER));
    r.to_state = 3'($urandom_range(7));
    r.accept = 1'($urandom_range(1));
    return r;
  endfunction

  // Offers one char transaction, after a random gap, and returns at the falling edge after
  // it is taken. Valid stays high on return so that back-to-back items need no toggle.
  task automatic send_char(input char_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_data <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_code(input logic [15:0] code);
    send_char(make_char(KIND_SYMBOL, code));
  endtask

  task automatic send_text(input int unsigned count);
    int unsigned sent;
    int unsigned run;
    int cls;
    sent = 0;
    while (sent < count) begin
      cls = $urandom_range(CLS_OTHER);
      run = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(5, 1);
      for (int unsigned k = 0; k < run && sent < count; k++) begin
        send_char(text_char(cls));
        sent++;
      end
    end
  endtask

  // Stops offering characters and waits until every expected token has been taken, then
  // lets the pipeline settle, since the last characters may have produced no token.
  task automatic drain();
    char_valid <= 1'b0;
    @(negedge clk);
    while (tokens_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the substitute byte, with junk in the unused upper bits, all four override
  // slots from the plan, and one write to an index that the block must ignore.
  task automatic load_config(input logic [7:0] subst);
    logic [CFG_DATA_BITS-1:0] value;
    value = CFG_DATA_BITS'($urandom);
    value[7:0] = subst;
    write_reg(CFG_WIDE_SUBST, value);
    write_reg(CFG_OVERRIDE_A, plan[0]);
    write_reg(CFG_OVERRIDE_B, plan[1]);
    write_reg(CFG_OVERRIDE_C, plan[2]);
    write_reg(CFG_OVERRIDE_D, plan[3]);
    write_reg(CFG_INDEX_BITS'(CFG_OVERRIDE_D + 1 + $urandom_range(2)),
              CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
    for (int i = 0; i < CFG_OVERRIDE_REGS; i++) hot_bytes[i] = plan[i].symbol;
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    char_valid = 1'b0;
    char_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < CFG_OVERRIDE_REGS; i++) hot_bytes[i] = "a";
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text at the reset configuration: class boundaries, the extreme bytes,
    // wide codes mapped to the default substitute, end markers and restarts.
    send_code("A");
    send_code("z");
    send_code("0");
    send_code("9");
    send_code(" ");
    send_code(8'd9);      // tab, still a space run
    send_code(8'd13);     // carriage return
    send_code("+");
    send_code("-");
    send_code(8'd255);
    send_code(16'h0100);  // smallest wide code
    send_code(16'hFFFF);  // largest wide code
    send_code(16'd0);     // end flushes the symbol token
    send_code(16'd0);     // end from start: nothing to flush
    send_char(make_char(KIND_RESTART, 16'hFFFF));
    send_code("x");
    send_char(make_char(KIND_RESTART, 16'd0));
    send_code("7");
    send_code(16'd0);
    drain();

    // A long word, closed by a symbol and the end marker.
    send_char(make_char(KIND_RESTART, 16'd0));
    for (int unsigned k = 0; k < LONG_WORD; k++) send_code({8'd0, class_byte(CLS_LETTER)});
    send_code(".");
    send_code(16'd0);
    drain();

    // Directed overrides. Slot a applies to '#' from every state and slot b overrides it
    // from word; slot c sets an accept from start, which must be ignored; slot d refuses '!'.
    plan[0] = make_override(ST_ALL, "#", ST_WORD, 1'b1);
    plan[1] = make_override(ST_WORD, "#", ST_SPACE, 1'b0);
    plan[2] = make_override(ST_START, "q", ST_NUMBER, 1'b1);
    plan[3] = make_override(ST_ALL, "!", ST_ERROR, 1'b1);
    load_config("!");
    send_code("#");       // slot a from start, no token
    send_code("#");       // slot b wins from word
    send_code("q");       // core rule ends the space run
    send_code(16'd0);
    send_code("q");       // slot c from start
    send_code("!");       // refused, the number run goes on
    send_code(16'h1234);  // wide code becomes '!', refused too
    send_code("5");
    send_code(16'd0);
    drain();
    // A slot that can never match, and a refusal through the largest to state.
    plan[2] = make_override(ST_ALL, "q", TO_TOP, 1'b0);
    plan[3] = make_override(FROM_NOWHERE, "!", ST_WORD, 1'b1);
    load_config(8'd0);
    send_code("q");
    send_code("!");
    send_code(16'hABCD);  // wide code becomes the end marker
    drain();

    // Random text under four idling patterns, each with its own configuration.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          for (int i = 0; i < CFG_OVERRIDE_REGS; i++) plan[i] = 16'hFFFF;
          load_config(8'd0);
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
          for (int i = 0; i < CFG_OVERRIDE_REGS; i++) plan[i] = random_override();
          load_config(8'd255);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
          for (int i = 0; i < CFG_OVERRIDE_REGS; i++) plan[i] = random_override();
          load_config(8'($urandom_range(255)));
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
          for (int i = 0; i < CFG_OVERRIDE_REGS; i++) plan[i] = '0;
          load_config(WIDE_SUBST_RESET);
        end
      endcase
      send_text(200);
      drain();
    end

    // Back pressure: the receiver holds off for a long stretch while alternating letters
    // and digits, each ending a token, fill the block until it refuses input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 40; k++) send_code((k % 2 == 0) ? "a" : "1");
    drain();

    if (mismatches == 0 && tokens_owed == 0) begin
      $display("[char_class_tokenizer] OK");
    end else begin
      $display("[char_class_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
